// File: rtl/core/rectangle_area_sorter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle area sorter
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RECTANGLE_AREA_SORTER_DEFINES_SVH
`define RECTANGLE_AREA_SORTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rasort_pkg.sv
// ----------------------------------------------------------------------------
// Rectangle area sorter package
// State encoding for the load, sort and emit sequencer, and RAM control bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rasort_pkg;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DRAIN = 7'b0000010,
        S_RDI   = 7'b0000100,
        S_GETI  = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_WB    = 7'b0100000,
        S_EMIT  = 7'b1000000
    } seq_state_t;

    typedef struct packed {
        logic we;
        logic re;
    } ram_ctl_t;

endpackage

// File: rtl/core/rectangle_area_sorter.sv
// ----------------------------------------------------------------------------
// Rectangle area sorter
// Collects rectangles, sorts them by area with an exchange sort held in one
// RAM, and emits the sorted set.
// ----------------------------------------------------------------------------
// Items are taken one per cycle while busy is low; an item beyond MAX_ITEMS
// is discarded and sets dropped on every result of its set. The item with
// last_item set raises busy, which stays high through the sort and emit
// phases: the sort compares one pair per cycle through the single read and
// write port of the entry RAM, with the S_RDI, S_GETI and S_WB states added
// to each outer pass, and the emit phase reads one entry per cycle. Each
// result appears for one cycle with out_valid, in the cycle after its read,
// so the last one appears as busy falls. The receiver cannot stall the
// results and must take each one as it appears.
`timescale 1ns / 1ps

`include "rectangle_area_sorter_defines.svh"

module rectangle_area_sorter #(
    parameter int MAX_ITEMS = 16,
    parameter int SIDE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] width,
    input  logic [15:0] length,
    input  logic        last_item,
    output logic        out_valid,
    output logic [15:0] out_width,
    output logic [15:0] out_length,
    output logic [31:0] out_area,
    output logic        out_last,
    output logic        dropped
);

    import rasort_pkg::*;

    localparam int AW         = $clog2(MAX_ITEMS);
    localparam int CW         = $clog2(MAX_ITEMS + 1);
    localparam int AREA_BITS  = 2 * SIDE_BITS;
    localparam int ENTRY_BITS = AREA_BITS + 2 * SIDE_BITS;

    seq_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          overflow_reg, overflow_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] k_reg, k_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg;
    logic [SIDE_BITS-1:0] w_s1_reg, l_s1_reg;
    logic [ENTRY_BITS-1:0] cur_reg, cur_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_last_reg, out_last_next;
    logic          dropped_reg, dropped_next;

    logic                  accept;
    logic                  room;
    ram_ctl_t              ram_ctl;
    logic [AW-1:0]         ram_waddr;
    logic [AW-1:0]         ram_raddr;
    logic [ENTRY_BITS-1:0] ram_wdata;
    logic [ENTRY_BITS-1:0] ram_rdata;
    logic [AREA_BITS-1:0]  load_area;
    logic [AREA_BITS-1:0]  cur_area;
    logic [AREA_BITS-1:0]  rd_area;
    logic                  swap;
    logic                  scan_last;
    logic                  pass_last;
    logic                  emit_last;

    assign accept    = start && !busy;
    assign room      = count_reg < CW'(MAX_ITEMS);
    assign load_area = AREA_BITS'(w_s1_reg) * AREA_BITS'(l_s1_reg);

    assign cur_area  = cur_reg[ENTRY_BITS-1 -: AREA_BITS];
    assign rd_area   = ram_rdata[ENTRY_BITS-1 -: AREA_BITS];
    assign swap      = cur_area > rd_area;
    assign scan_last = (CW'(j_reg) + CW'(1)) == count_reg;
    assign pass_last = (CW'(i_reg) + CW'(2)) == count_reg;
    assign emit_last = (CW'(k_reg) + CW'(1)) == count_reg;

    rasort_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_ctl.we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_ctl.re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        pend_next      = 1'b0;
        cur_next       = cur_reg;
        out_valid_next = 1'b0;
        out_last_next  = 1'b0;
        dropped_next   = dropped_reg;
        ram_ctl.we     = 1'b0;
        ram_ctl.re     = 1'b0;
        ram_waddr      = j_reg;
        ram_wdata      = cur_reg;
        ram_raddr      = i_reg;

        if (pend_reg)
        begin
            ram_ctl.we = 1'b1;
            ram_waddr  = pend_addr_reg;
            ram_wdata  = {load_area, w_s1_reg, l_s1_reg};
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        pend_next  = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (last_item)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                i_next = '0;
                k_next = '0;
                if (count_reg < CW'(2))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_RDI;
                end
            end
            S_RDI:
            begin
                ram_ctl.re = 1'b1;
                ram_raddr  = i_reg;
                state_next = S_GETI;
            end
            S_GETI:
            begin
                cur_next   = ram_rdata;
                ram_ctl.re = 1'b1;
                ram_raddr  = i_reg + AW'(1);
                j_next     = i_reg + AW'(1);
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (swap)
                begin
                    ram_ctl.we = 1'b1;
                    ram_waddr  = j_reg;
                    ram_wdata  = cur_reg;
                    cur_next   = ram_rdata;
                end
                if (scan_last)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    ram_ctl.re = 1'b1;
                    ram_raddr  = j_reg + AW'(1);
                    j_next     = j_reg + AW'(1);
                end
            end
            S_WB:
            begin
                ram_ctl.we = 1'b1;
                ram_waddr  = i_reg;
                ram_wdata  = cur_reg;
                i_next     = i_reg + AW'(1);
                if (pass_last)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_RDI;
                end
            end
            S_EMIT:
            begin
                ram_ctl.re     = 1'b1;
                ram_raddr      = k_reg;
                out_valid_next = 1'b1;
                out_last_next  = emit_last;
                dropped_next   = overflow_reg;
                k_next         = k_reg + AW'(1);
                if (emit_last)
                begin
                    state_next    = S_IDLE;
                    count_next    = '0;
                    overflow_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        cur_reg      <= cur_next;
        out_last_reg <= out_last_next;
        dropped_reg  <= dropped_next;
        if (accept)
        begin
            pend_addr_reg <= AW'(count_reg);
            w_s1_reg      <= SIDE_BITS'(width);
            l_s1_reg      <= SIDE_BITS'(length);
        end
    end

    assign busy       = state_reg != S_IDLE;
    assign out_valid  = out_valid_reg;
    assign out_last   = out_last_reg;
    assign dropped    = dropped_reg;
    assign out_width  = 16'(ram_rdata[2*SIDE_BITS-1 -: SIDE_BITS]);
    assign out_length = 16'(ram_rdata[SIDE_BITS-1:0]);
    assign out_area   = 32'(ram_rdata[ENTRY_BITS-1 -: AREA_BITS]);

    `RAS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(MAX_ITEMS),
        "entry count exceeds capacity")
    `RAS_ASSERT_NOW(a_no_same_entry, ram_ctl.we && ram_ctl.re, ram_waddr != ram_raddr,
        "read and write of the same entry in one cycle")
    `RAS_ASSERT_NOW(a_set_cleared, $fell(busy), count_reg == '0 && !overflow_reg,
        "set state not cleared at end of output")
    `RAS_ASSERT_NEXT(a_last_ends, out_valid && out_last, !out_valid,
        "result transaction follows the final result")

endmodule

// File: rtl/core/rasort_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rasort_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
